FILE: rtl/lmsm4_pkg.sv
// ----------------------------------------------------------------------------
// lmsm4_pkg
// Shared types, constants and functions of the 256-bit Lai-Massey SM4 cipher.
// ----------------------------------------------------------------------------
package lmsm4_pkg;

    // Item kinds carried in tuser.
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_ENC  = 2'd1;
    localparam logic [1:0] KIND_DEC  = 2'd2;

    // Cipher geometry.
    localparam int NUM_ROUND_KEYS_DEF = 32;
    localparam int NUM_STAGES         = 8;
    localparam int STEP_W             = $clog2(NUM_STAGES);
    localparam int KEY_LANES          = 4;
    localparam int LANE_W             = $clog2(KEY_LANES);
    localparam int WORD_W             = 32;
    localparam int SLOT_W             = 5;

    // Input tdata layout, lowest bit first.
    localparam int SLOT_LSB     = 0;
    localparam int KEY_LSB      = SLOT_LSB + SLOT_W;
    localparam int LEFT_HI_LSB  = KEY_LSB + WORD_W;
    localparam int LEFT_LO_LSB  = LEFT_HI_LSB + 64;
    localparam int RIGHT_HI_LSB = LEFT_LO_LSB + 64;
    localparam int RIGHT_LO_LSB = RIGHT_HI_LSB + 64;
    localparam int IN_BITS      = RIGHT_LO_LSB + 64;
    localparam int IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W   = 256;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic key_we;        // write a round key word
        logic key_re;        // fetch the next key group
        logic start;         // capture a new block into the work registers
        logic step_en;       // run one Lai-Massey stage
        logic last;          // this stage is the final one (no rotation)
        logic dec;           // current item is a decryption
        logic out_load;      // load the output register
        logic out_from_stage; // output comes from the stage result, not the work registers
    } t_cmd;

    localparam logic [7:0] SBOX [256] = '{
        8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7, 8'h16, 8'hB6, 8'h14, 8'hC2,
        8'h28, 8'hFB, 8'h2C, 8'h05, 8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
        8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99, 8'h9C, 8'h42, 8'h50, 8'hF4,
        8'h91, 8'hEF, 8'h98, 8'h7A, 8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
        8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95, 8'h80, 8'hDF, 8'h94, 8'hFA,
        8'h75, 8'h8F, 8'h3F, 8'hA6, 8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
        8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8, 8'h68, 8'h6B, 8'h81, 8'hB2,
        8'h71, 8'h64, 8'hDA, 8'h8B, 8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
        8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2, 8'h25, 8'h22, 8'h7C, 8'h3B,
        8'h01, 8'h21, 8'h78, 8'h87, 8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
        8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E, 8'hEA, 8'hBF, 8'h8A, 8'hD2,
        8'h40, 8'hC7, 8'h38, 8'hB5, 8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
        8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55, 8'hAD, 8'h93, 8'h32, 8'h30,
        8'hF5, 8'h8C, 8'hB1, 8'hE3, 8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
        8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F, 8'hD5, 8'hDB, 8'h37, 8'h45,
        8'hDE, 8'hFD, 8'h8E, 8'h2F, 8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
        8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F, 8'h11, 8'hD9, 8'h5C, 8'h41,
        8'h1F, 8'h10, 8'h5A, 8'hD8, 8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
        8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0, 8'h89, 8'h69, 8'h97, 8'h4A,
        8'h0C, 8'h96, 8'h77, 8'h7E, 8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
        8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20, 8'h79, 8'hEE, 8'h5F, 8'h3E,
        8'hD7, 8'hCB, 8'h39, 8'h48
    };

    // Rotate a word left by a constant amount between 1 and 31.
    function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // SM4 mixer: byte-wise S-box followed by the linear transform.
    function automatic logic [31:0] sm4_t(input logic [31:0] x);
        logic [31:0] b;
        b = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
        return b ^ rotl32(b, 2) ^ rotl32(b, 10) ^ rotl32(b, 18) ^ rotl32(b, 24);
    endfunction

endpackage

FILE: rtl/lmsm4_ram.sv
// ----------------------------------------------------------------------------
// lmsm4_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lmsm4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/lmsm4_ctrl.sv
// ----------------------------------------------------------------------------
// lmsm4_ctrl
// Controller: accepts items, sequences the eight cipher stages and hands the
// finished block to the output register.
// ----------------------------------------------------------------------------
module lmsm4_ctrl
    import lmsm4_pkg::*;
#(
    parameter int NUM_ROUND_KEYS = NUM_ROUND_KEYS_DEF,
    parameter int KGW            = $clog2(NUM_ROUND_KEYS / KEY_LANES)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_kind,
    input  logic           i_out_free,
    output logic           o_in_ready,
    output t_cmd           o_cmd,
    output logic [KGW-1:0] o_key_grp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_dec, n_dec;
    logic              w_accept;
    logic [STEP_W-1:0] w_next_stage;
    logic [STEP_W-1:0] w_grp;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Next state and command decode.
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_dec        = r_dec;
        o_cmd        = '0;
        o_cmd.dec    = r_dec;
        w_next_stage = r_step + STEP_W'(1);
        unique case (r_state)
            ST_IDLE: begin
                w_next_stage = '0;
                o_cmd.dec    = (i_kind == KIND_DEC);
                if (w_accept) begin
                    unique case (i_kind) inside
                        KIND_LOAD: begin
                            o_cmd.key_we = 1'b1;
                        end
                        KIND_ENC, KIND_DEC: begin
                            o_cmd.start  = 1'b1;
                            o_cmd.key_re = 1'b1;
                            n_state      = ST_RUN;
                            n_step       = '0;
                            n_dec        = (i_kind == KIND_DEC);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                o_cmd.step_en = 1'b1;
                if (r_step == STEP_W'(NUM_STAGES - 1)) begin
                    o_cmd.last = 1'b1;
                    if (i_out_free) begin
                        o_cmd.out_load       = 1'b1;
                        o_cmd.out_from_stage = 1'b1;
                        n_state              = ST_IDLE;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else begin
                    o_cmd.key_re = 1'b1;
                    n_step       = r_step + STEP_W'(1);
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Key group for the stage that follows; decryption walks groups backward.
    assign w_grp     = o_cmd.dec ? (STEP_W'(NUM_STAGES - 1) - w_next_stage) : w_next_stage;
    assign o_key_grp = KGW'(w_grp);

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_dec   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_dec   <= n_dec;
        end
    end

endmodule

FILE: rtl/lmsm4_dp.sv
// ----------------------------------------------------------------------------
// lmsm4_dp
// Datapath: round key store, block work registers, one Lai-Massey stage of
// four SM4 rounds, and the output register.
// ----------------------------------------------------------------------------
module lmsm4_dp
    import lmsm4_pkg::*;
#(
    parameter int NUM_ROUND_KEYS = NUM_ROUND_KEYS_DEF,
    parameter int KGW            = $clog2(NUM_ROUND_KEYS / KEY_LANES)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [KGW-1:0]        i_key_grp,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [OUT_DATA_W-1:0] o_out_data,
    output logic                  o_out_free
);

    logic [SLOT_W-1:0]  w_slot;
    logic [WORD_W-1:0]  w_key_word;
    logic [63:0]        w_lhi, w_llo, w_rhi, w_rlo;
    logic [WORD_W-1:0]  w_lw [KEY_LANES];
    logic [WORD_W-1:0]  w_rw [KEY_LANES];
    logic [WORD_W-1:0]  w_key [KEY_LANES];
    logic [WORD_W-1:0]  r_l [KEY_LANES];
    logic [WORD_W-1:0]  r_r [KEY_LANES];
    logic [WORD_W-1:0]  w_f [KEY_LANES];
    logic [WORD_W-1:0]  w_sl [KEY_LANES];
    logic [WORD_W-1:0]  w_sr [KEY_LANES];
    logic [WORD_W-1:0]  w_ol [KEY_LANES];
    logic [WORD_W-1:0]  w_or [KEY_LANES];
    logic [OUT_DATA_W-1:0] r_out_data;
    logic               r_out_valid;

    // Field extraction from the input item.
    assign w_slot     = i_in_data[SLOT_LSB +: SLOT_W];
    assign w_key_word = i_in_data[KEY_LSB +: WORD_W];
    assign w_lhi      = i_in_data[LEFT_HI_LSB +: 64];
    assign w_llo      = i_in_data[LEFT_LO_LSB +: 64];
    assign w_rhi      = i_in_data[RIGHT_HI_LSB +: 64];
    assign w_rlo      = i_in_data[RIGHT_LO_LSB +: 64];

    // Big-endian words of each half, reversed for decryption.
    always_comb begin
        logic [WORD_W-1:0] lw [KEY_LANES];
        logic [WORD_W-1:0] rw [KEY_LANES];
        lw[0] = w_lhi[63:32];
        lw[1] = w_lhi[31:0];
        lw[2] = w_llo[63:32];
        lw[3] = w_llo[31:0];
        rw[0] = w_rhi[63:32];
        rw[1] = w_rhi[31:0];
        rw[2] = w_rlo[63:32];
        rw[3] = w_rlo[31:0];
        for (int i = 0; i < KEY_LANES; i++) begin
            w_lw[i] = i_cmd.dec ? lw[KEY_LANES - 1 - i] : lw[i];
            w_rw[i] = i_cmd.dec ? rw[KEY_LANES - 1 - i] : rw[i];
        end
    end

    // Round key store: one RAM per key lane, addressed by key group.
    for (genvar g = 0; g < KEY_LANES; g++) begin : g_key_lane
        lmsm4_ram #(
            .WIDTH (WORD_W),
            .DEPTH (NUM_ROUND_KEYS / KEY_LANES)
        ) u_key_ram (
            .i_clk   (i_clk),
            .i_we    (i_cmd.key_we && (w_slot[LANE_W-1:0] == LANE_W'(g))),
            .i_waddr (w_slot[LANE_W +: KGW]),
            .i_wdata (w_key_word),
            .i_re    (i_cmd.key_re),
            .i_raddr (i_key_grp),
            .o_rdata (w_key[g])
        );
    end

    // One Lai-Massey stage: four chained SM4 rounds on L xor R.
    always_comb begin
        for (int i = 0; i < KEY_LANES; i++) begin
            w_f[i] = r_l[i] ^ r_r[i];
        end
        for (int i = 0; i < KEY_LANES; i++) begin
            w_f[i] = w_f[i] ^ sm4_t(w_f[(i + 1) % KEY_LANES] ^ w_f[(i + 2) % KEY_LANES]
                                    ^ w_f[(i + 3) % KEY_LANES] ^ w_key[i]);
        end
        for (int i = 0; i < KEY_LANES; i++) begin
            w_sl[i] = r_l[i] ^ w_f[i];
            w_sr[i] = r_r[i] ^ w_f[i];
            if (!i_cmd.last) begin
                w_sl[i] = i_cmd.dec ? rotl32(w_sl[i], 25) : rotl32(w_sl[i], 7);
                w_sr[i] = i_cmd.dec ? rotl32(w_sr[i], 29) : rotl32(w_sr[i], 3);
            end
        end
    end

    // Work registers.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < KEY_LANES; i++) begin
            if (i_cmd.start) begin
                r_l[i] <= w_lw[i];
                r_r[i] <= w_rw[i];
            end else if (i_cmd.step_en) begin
                r_l[i] <= w_sl[i];
                r_r[i] <= w_sr[i];
            end
        end
    end

    // Output word order: reversed for encryption.
    always_comb begin
        for (int i = 0; i < KEY_LANES; i++) begin
            w_ol[i] = i_cmd.out_from_stage ? w_sl[i] : r_l[i];
            w_or[i] = i_cmd.out_from_stage ? w_sr[i] : r_r[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.dec) begin
                r_out_data <= {w_or[2], w_or[3], w_or[0], w_or[1],
                               w_ol[2], w_ol[3], w_ol[0], w_ol[1]};
            end else begin
                r_out_data <= {w_or[1], w_or[0], w_or[3], w_or[2],
                               w_ol[1], w_ol[0], w_ol[3], w_ol[2]};
            end
        end
    end

    // Output valid: set on load, cleared when the transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_free  = !r_out_valid || i_out_ready;

endmodule

FILE: rtl/lai_massey_sm4_block_cipher_256_core.sv
// ----------------------------------------------------------------------------
// lai_massey_sm4_block_cipher_256_core
// 256-bit Lai-Massey block cipher on the SM4 round function, with a loadable
// store of 32 round key words.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the s_axis channel; tuser selects the kind: load a round
// key word, encrypt a block or decrypt a block. A load writes key_word into
// slot key_slot in its accepting cycle and gives no result. Every key that a
// cipher item reads must have been loaded since reset. Kind 3 is dropped.
// An encrypt or decrypt item runs eight stages, one per cycle, in a single
// shared stage unit of four SM4 rounds; the key group for each stage is read
// from the key RAMs in the cycle before that stage runs. No new item is
// accepted while the stages run; the result goes to m_axis through the
// output register. After a load the input stays ready for the next item.
// The result sits in an output register, so the next item is accepted while
// it waits. If the receiver stalls and the register is still full when the
// next block finishes, the block holds that result and accepts nothing until
// the register frees. Reset clears the controller and the output valid; the
// key store keeps its contents and is undefined until loaded.
// ----------------------------------------------------------------------------
module lai_massey_sm4_block_cipher_256_core
    import lmsm4_pkg::*;
#(
    parameter int NUM_ROUND_KEYS = NUM_ROUND_KEYS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: key_slot, key_word, left_hi, left_lo, right_hi, right_lo, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: kind
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: out_left_hi, out_left_lo, out_right_hi, out_right_lo
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int KGW = $clog2(NUM_ROUND_KEYS / KEY_LANES);

    t_cmd           w_cmd;
    logic [KGW-1:0] w_key_grp;
    logic           w_out_free;

    lmsm4_ctrl #(
        .NUM_ROUND_KEYS (NUM_ROUND_KEYS),
        .KGW            (KGW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_kind     (s_axis_tuser),
        .i_out_free (w_out_free),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd),
        .o_key_grp  (w_key_grp)
    );

    lmsm4_dp #(
        .NUM_ROUND_KEYS (NUM_ROUND_KEYS),
        .KGW            (KGW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_key_grp   (w_key_grp),
        .i_in_data   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_free  (w_out_free)
    );

    // A pending result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register overwritten while a result was pending");

    // A started block runs its first stage in the next cycle.
    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.start |=> w_cmd.step_en)
        else $error("cipher stage did not follow a start");

    // No item is accepted while a stage is running.
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step_en |-> !s_axis_tready)
        else $error("input accepted while a block was in progress");

    // A result appears only after an output load.
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_cmd.out_load))
        else $error("output valid rose without an output load");

endmodule

FILE: verif/lai_massey_sm4_block_cipher_256_core_tb.sv
// ----------------------------------------------------------------------------
// lai_massey_sm4_block_cipher_256_core_tb
// Self-checking bench for the 256-bit Lai-Massey SM4 block cipher core.
// The bench first loads all 32 round key words, then runs directed corner
// blocks, then sends a long random mix. The mix holds key rewrites,
// encryptions, decryptions (some of them decrypting the previous ciphertext)
// and dropped items. An in-bench model of the cipher predicts every result.
// The input side sends in bursts with gaps, and the output side stalls on
// its own pattern, with long hold-offs that fill the core and block its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lai_massey_sm4_block_cipher_256_core_tb;
    import lmsm4_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 410;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 30;

    // One input transaction, split into its fields.
    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  slot;
        logic [31:0] key_word;
        logic [63:0] left_hi;
        logic [63:0] left_lo;
        logic [63:0] right_hi;
        logic [63:0] right_lo;
    } cipher_item_t;

    // Cipher model, key store copy and queue of blocks still to come out.
    class cipher_checker;
        logic [31:0]  round_key [32];
        logic [255:0] pending_blocks [$];
        logic [255:0] last_cipher;
        bit           have_cipher;
        int           errors;
        int           checked;
        int           n_load;
        int           n_enc;
        int           n_dec;
        int           n_drop;
        string        field_names [4] = '{"out_left_hi", "out_left_lo",
                                          "out_right_hi", "out_right_lo"};

        function logic [31:0] rotl(logic [31:0] x, int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        // S-box on every byte, then the linear diffusion.
        function logic [31:0] sm4_mix(logic [31:0] x);
            logic [31:0] b;
            b = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
            return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
        endfunction

        // Full eight-stage cipher; returns the packed output tdata.
        function logic [255:0] lm_crypt(bit dec, cipher_item_t it);
            logic [31:0] wl [4];
            logic [31:0] wr [4];
            logic [31:0] l [4];
            logic [31:0] r [4];
            logic [31:0] f [4];
            int base;
            wl = '{it.left_hi[63:32], it.left_hi[31:0], it.left_lo[63:32], it.left_lo[31:0]};
            wr = '{it.right_hi[63:32], it.right_hi[31:0],
                   it.right_lo[63:32], it.right_lo[31:0]};
            for (int i = 0; i < 4; i++) begin
                l[i] = wl[dec ? 3 - i : i];
                r[i] = wr[dec ? 3 - i : i];
            end
            for (int s = 0; s < 8; s++) begin
                base = 4 * (dec ? 7 - s : s);
                for (int i = 0; i < 4; i++) begin
                    f[i] = l[i] ^ r[i];
                end
                for (int i = 0; i < 4; i++) begin
                    f[i] ^= sm4_mix(f[(i + 1) % 4] ^ f[(i + 2) % 4] ^ f[(i + 3) % 4] ^
                                    round_key[base + i]);
                end
                for (int i = 0; i < 4; i++) begin
                    l[i] ^= f[i];
                    r[i] ^= f[i];
                    // The last stage leaves the halves unrotated.
                    if (s < 7) begin
                        l[i] = rotl(l[i], dec ? 25 : 7);
                        r[i] = rotl(r[i], dec ? 29 : 3);
                    end
                end
            end
            if (dec) begin
                return {r[2], r[3], r[0], r[1], l[2], l[3], l[0], l[1]};
            end else begin
                return {r[1], r[0], r[3], r[2], l[1], l[0], l[3], l[2]};
            end
        endfunction

        // Account for an accepted input transaction.
        function void note_item(cipher_item_t it);
            case (it.kind)
                KIND_LOAD: begin
                    round_key[it.slot] = it.key_word;
                    n_load++;
                end
                KIND_ENC: begin
                    last_cipher = lm_crypt(1'b0, it);
                    have_cipher = 1'b1;
                    pending_blocks.push_back(last_cipher);
                    n_enc++;
                end
                KIND_DEC: begin
                    pending_blocks.push_back(lm_crypt(1'b1, it));
                    n_dec++;
                end
                default: begin
                    n_drop++;
                end
            endcase
        endfunction

        // Compare an output transaction against the oldest pending block.
        function void check_block(logic [255:0] got);
            logic [255:0] want;
            if (pending_blocks.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_blocks.pop_front();
            checked++;
            for (int k = 0; k < 4; k++) begin
                if (want[64*k +: 64] !== got[64*k +: 64]) begin
                    $display("%0t: mismatch in %s: expected %h, actual %h", $time,
                             field_names[k], want[64*k +: 64], got[64*k +: 64]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // tdata: key_slot, key_word, left_hi, left_lo, right_hi, right_lo, zero pad
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // tuser: kind
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // tdata: out_left_hi, out_left_lo, out_right_hi, out_right_lo
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    cipher_checker sb = new();
    int            stall_cycles;
    int            round_trips;
    int            hold_offs;

    lai_massey_sm4_block_cipher_256_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic cipher_item_t random_item(logic [1:0] kind);
        cipher_item_t it;
        it.kind     = kind;
        it.slot     = 5'($urandom_range(0, 31));
        it.key_word = $urandom;
        it.left_hi  = {$urandom, $urandom};
        it.left_lo  = {$urandom, $urandom};
        it.right_hi = {$urandom, $urandom};
        it.right_lo = {$urandom, $urandom};
        return it;
    endfunction

    // Decrypt item whose halves are the most recent ciphertext.
    function automatic cipher_item_t round_trip_item();
        cipher_item_t it;
        it          = random_item(KIND_DEC);
        it.left_hi  = sb.last_cipher[63:0];
        it.left_lo  = sb.last_cipher[127:64];
        it.right_hi = sb.last_cipher[191:128];
        it.right_lo = sb.last_cipher[255:192];
        return it;
    endfunction

    // Present one item from a falling edge and hold it until accepted.
    task automatic send_item(input cipher_item_t it);
        s_axis_tdata = '0;
        s_axis_tdata[SLOT_LSB +: SLOT_W]   = it.slot;
        s_axis_tdata[KEY_LSB +: WORD_W]    = it.key_word;
        s_axis_tdata[LEFT_HI_LSB +: 64]    = it.left_hi;
        s_axis_tdata[LEFT_LO_LSB +: 64]    = it.left_lo;
        s_axis_tdata[RIGHT_HI_LSB +: 64]   = it.right_hi;
        s_axis_tdata[RIGHT_LO_LSB +: 64]   = it.right_lo;
        s_axis_tuser  = it.kind;
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_item(it);
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Stimulus: reset, key loads, directed corners, then the random mix.
    initial begin
        cipher_item_t it;
        int burst;
        int sent;
        int pick;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_LOAD;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Fill the whole key store; extreme words in the first and last slot,
        // block halves of a load held at all ones to show they are ignored.
        for (int k = 0; k < 32; k++) begin
            it          = random_item(KIND_LOAD);
            it.slot     = 5'(k);
            it.key_word = (k == 0) ? 32'h0 : (k == 31) ? 32'hFFFF_FFFF : it.key_word;
            it.left_hi  = '1;
            it.left_lo  = '1;
            it.right_hi = '1;
            it.right_lo = '1;
            send_item(it);
        end

        // All-zero and all-one blocks in both directions.
        it = random_item(KIND_ENC);
        {it.left_hi, it.left_lo, it.right_hi, it.right_lo} = '0;
        send_item(it);
        it = random_item(KIND_ENC);
        {it.left_hi, it.left_lo, it.right_hi, it.right_lo} = '1;
        send_item(it);
        it = random_item(KIND_DEC);
        {it.left_hi, it.left_lo, it.right_hi, it.right_lo} = '0;
        send_item(it);
        it = random_item(KIND_DEC);
        {it.left_hi, it.left_lo, it.right_hi, it.right_lo} = '1;
        send_item(it);

        // Equal halves give L xor R = 0 in the first stage; unused fields all ones.
        it          = random_item(KIND_ENC);
        it.slot     = '1;
        it.key_word = '1;
        it.right_hi = it.left_hi;
        it.right_lo = it.left_lo;
        send_item(it);

        // The unused kind must be dropped without a result.
        send_item(random_item(KIND_UNUSED));

        // Rewrite a key, encrypt, then decrypt that ciphertext right away.
        it          = random_item(KIND_LOAD);
        it.slot     = 31;
        it.key_word = 32'h8000_0001;
        send_item(it);
        send_item(random_item(KIND_ENC));
        send_item(round_trip_item());
        round_trips++;

        // Random mix in bursts, with gaps of random length in between.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16);
            if (burst > RANDOM_ITEMS - sent) begin
                burst = RANDOM_ITEMS - sent;
            end
            repeat (burst) begin
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    it = random_item(KIND_LOAD);
                end else if (pick < 60) begin
                    it = random_item(KIND_ENC);
                end else if (pick < 92) begin
                    if (sb.have_cipher && $urandom_range(0, 1) == 1) begin
                        it = round_trip_item();
                        round_trips++;
                    end else begin
                        it = random_item(KIND_DEC);
                    end
                end else begin
                    it = random_item(KIND_UNUSED);
                end
                send_item(it);
                sent++;
            end
            idle_cycles(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
        end
        s_axis_tvalid = 1'b0;

        // Drain every outstanding block, then allow a few extra cycles.
        while (sb.pending_blocks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d key loads, %0d encryptions and %0d decryptions (%0d round trips).",
                 sb.n_load, sb.n_enc, sb.n_dec, round_trips);
        $display("Dropped %0d unused items; checked %0d blocks across %0d output hold-offs.",
                 sb.n_drop, sb.checked, hold_offs);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Output side: the ready pattern is picked at random from four modes, and two long
    // hold-offs let the core fill up and stall its input.
    initial begin
        int cyc;
        int mode;
        cyc           = 0;
        mode          = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (i_rst_n) begin
                cyc++;
                if (cyc % 64 == 0) begin
                    mode = $urandom_range(0, 3);
                end
                if (cyc == 1000 || cyc == 2500) begin
                    hold_offs++;
                end
                if ((cyc >= 1000 && cyc < 1250) || (cyc >= 2500 && cyc < 2650)) begin
                    m_axis_tready = 1'b0;
                end else begin
                    case (mode)
                        0:       m_axis_tready = 1'b1;
                        1:       m_axis_tready = ($urandom_range(0, 3) != 0);
                        2:       m_axis_tready = cyc[0];
                        default: m_axis_tready = ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    // Output monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_block(m_axis_tdata);
        end
    end

    // Watchdog: stop if no transaction happens on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

FILE: lai_massey_sm4_block_cipher_256_core.f
rtl/lmsm4_pkg.sv
rtl/lmsm4_ram.sv
rtl/lmsm4_ctrl.sv
rtl/lmsm4_dp.sv
rtl/lai_massey_sm4_block_cipher_256_core.sv
verif/lai_massey_sm4_block_cipher_256_core_tb.sv
